@@ rtl/mfpp_pkg.sv @@
package mfpp_pkg;

  // Size of the receive buffer in bytes.
  localparam int BUF_SIZE = 256;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int WIN_BYTES = 5;
  localparam int WIN_W  = WIN_BYTES * BYTE_W;
  localparam int FILL_W = $clog2(WIN_BYTES + 1);
  localparam int CNT_W  = $clog2(BUF_SIZE + 1);
  // Width used to test length against free space without overflow.
  localparam int CMP_W  = (LEN_W > CNT_W ? LEN_W : CNT_W) + 1;

  localparam logic [BYTE_W-1:0] CHAR_K = 8'h4B;
  localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2,
    PH_FAULT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              start_over;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              last;
    logic              header_found;
    logic [LEN_W-1:0]  length_seen;
    logic              fault;
    logic              completed;
  } res_word_t;

endpackage

@@ rtl/mfpp_core.sv @@
module mfpp_core
  import mfpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_word
);

  // Input register.
  logic     hold_valid;
  in_word_t hold;

  // Parser state.
  logic [WIN_W-1:0]  byte_window;
  logic [FILL_W-1:0] window_fill;
  logic [CNT_W-1:0]  bytes_received;
  phase_t            phase;
  logic [LEN_W-1:0]  payload_left;
  logic [LEN_W-1:0]  accepted_length;

  logic [WIN_W-1:0]  byte_window_next;
  logic [FILL_W-1:0] window_fill_next;
  logic [CNT_W-1:0]  bytes_received_next;
  phase_t            phase_next;
  logic [LEN_W-1:0]  payload_left_next;
  logic [LEN_W-1:0]  accepted_length_next;
  logic              hfound;
  logic              plast;
  logic              pvalid;

  logic              commit;
  logic              active;
  logic              match;
  logic              fits;
  logic [LEN_W-1:0]  win_len;
  logic [CNT_W-1:0]  rcv_inc;

  assign commit    = hold_valid && res_ready;
  assign in_ready  = !hold_valid || res_ready;
  assign res_valid = hold_valid;

  assign active  = (phase == PH_SEARCH || phase == PH_PAYLOAD) &&
                   (CMP_W'(bytes_received) < CMP_W'(BUF_SIZE));
  assign rcv_inc = bytes_received + CNT_W'(1);
  assign win_len = {byte_window[15:8], byte_window[23:16]};
  assign match   = (CMP_W'(window_fill) >= CMP_W'(WIN_BYTES)) &&
                   byte_window[39:32] == CHAR_K && byte_window[31:24] == CHAR_T &&
                   byte_window[7:0] == CHAR_T && hold.rx_byte == CHAR_K;
  assign fits    = (CMP_W'(win_len) + CMP_W'(rcv_inc)) <= CMP_W'(BUF_SIZE);

  // Next state.
  always_comb begin
    byte_window_next     = byte_window;
    window_fill_next     = window_fill;
    bytes_received_next  = bytes_received;
    phase_next           = phase;
    payload_left_next    = payload_left;
    accepted_length_next = accepted_length;
    hfound               = 1'b0;
    plast                = 1'b0;
    pvalid               = 1'b0;
    if (hold.start_over) begin
      byte_window_next     = '0;
      window_fill_next     = '0;
      bytes_received_next  = '0;
      phase_next           = PH_SEARCH;
      payload_left_next    = '0;
      accepted_length_next = '0;
    end else if (active) begin
      bytes_received_next = rcv_inc;
      if (phase == PH_SEARCH) begin
        if (match) begin
          if (fits) begin
            hfound               = 1'b1;
            accepted_length_next = win_len;
            payload_left_next    = win_len;
            if (win_len == '0) begin
              plast      = 1'b1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            phase_next = PH_FAULT;
          end
        end else begin
          byte_window_next = {byte_window[WIN_W-BYTE_W-1:0], hold.rx_byte};
          if (CMP_W'(window_fill) < CMP_W'(WIN_BYTES)) begin
            window_fill_next = window_fill + FILL_W'(1);
          end
        end
      end else begin
        pvalid = 1'b1;
        if (payload_left != '0) begin
          payload_left_next = payload_left - LEN_W'(1);
        end
        if (payload_left_next == '0) begin
          plast      = 1'b1;
          phase_next = PH_DONE;
        end
      end
    end
  end

  // Result word, taken from the state after this byte.
  always_comb begin
    res_word.payload_byte  = pvalid ? hold.rx_byte : '0;
    res_word.payload_valid = pvalid;
    res_word.last          = plast;
    res_word.header_found  = hfound;
    res_word.length_seen   = accepted_length_next;
    res_word.fault         = (phase_next == PH_FAULT);
    res_word.completed     = (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window     <= '0;
      window_fill     <= '0;
      bytes_received  <= '0;
      phase           <= PH_SEARCH;
      payload_left    <= '0;
      accepted_length <= '0;
    end else if (commit) begin
      byte_window     <= byte_window_next;
      window_fill     <= window_fill_next;
      bytes_received  <= bytes_received_next;
      phase           <= phase_next;
      payload_left    <= payload_left_next;
      accepted_length <= accepted_length_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(bytes_received) <= CMP_W'(BUF_SIZE))
    else $error("byte count ran past the buffer size");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> (payload_left != '0 && payload_left <= accepted_length))
    else $error("payload counter out of range while receiving payload");

  a_start_over: assert property (@(posedge clk) disable iff (rst)
    commit && hold.start_over |=> phase == PH_SEARCH && bytes_received == '0 &&
                                  window_fill == '0 && accepted_length == '0)
    else $error("start over did not clear the parser");

  a_header_excl: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> !(res_word.header_found && res_word.payload_valid))
    else $error("header and payload flagged on the same byte");

endmodule

@@ rtl/mfpp_obuf.sv @@
module mfpp_obuf
  import mfpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  output logic      res_ready,
  input  res_word_t res_word,
  output logic      out_valid,
  input  logic      out_ready,
  output res_word_t out_word
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_word <= res_word;
    end
  end

endmodule

@@ rtl/magic_framed_packet_parser_top.sv @@
// Byte-serial parser for one framed packet received over a serial link.
// The slave channel (s_*) takes one received byte per word; s_tuser set to 1
// clears all parser state and the byte is then ignored. The parser slides a
// six-byte view over the stream looking for the header 'K','T',len_lo,
// len_hi,'T','K'. A header is accepted only when its length fits in the
// space left in the buffer, otherwise the fault flag latches until the next
// start over. Accepted payload bytes come out flagged valid; the last one, or
// the header itself for a zero length, sets m_tlast and the sticky completed
// flag. The master channel (m_*) returns exactly one result word per input
// word, in order. A word accepted is held in the input register, passes
// through the parser logic to the result register, and is offered on
// m_tvalid from there. One word is taken per cycle when the receiver keeps
// m_tready high; the rate is set by the single update of the parser state per
// byte. When the receiver stalls, the result register holds its word and the
// input register fills; s_tready then drops until the receiver takes a word.
// Reset clears the parser state and the valid bits of both register stages;
// the words held in those registers are not cleared.
module magic_framed_packet_parser_top
  import mfpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] start_over
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] length_seen
  output logic [3:0]  m_tuser,   // [0] payload_valid, [1] header_found,
                                 // [2] fault, [3] completed
  output logic        m_tlast    // last payload byte, packet complete
);

  in_word_t  in_word;
  res_word_t res_word;
  res_word_t out_word;
  logic      res_valid;
  logic      res_ready;

  assign in_word.rx_byte    = s_tdata;
  assign in_word.start_over = s_tuser;

  mfpp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  mfpp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {out_word.length_seen, out_word.payload_byte};
  assign m_tuser = {out_word.completed, out_word.fault,
                    out_word.header_found, out_word.payload_valid};
  assign m_tlast = out_word.last;

endmodule
